// ===== rtl/sdaq_pkg.sv =====
`timescale 1ns / 1ps
// sdaq_pkg: shared types, constants and state codes of the deadline alarm queue.
// No dependencies; imported by sorted_deadline_alarm_queue.
package sdaq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TIME_WIDTH_DEF  = 32;

   localparam int ID_W      = 8;
   localparam int DUR_W     = 16;
   localparam int NOW_W     = 32;
   localparam int TPU_W     = 10;
   localparam int PROD_W    = DUR_W + TPU_W;
   localparam int CNT_OUT_W = 5;

   localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(100);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   // register index = byte address / 4
   localparam logic [0:0] REG_TICKS_PER_UNIT = 1'b0;

   localparam logic OP_SLEEP = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic             operation;
      logic [ID_W-1:0]  waiter_id;
      logic [DUR_W-1:0] duration;
      logic [NOW_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic                 woke;
      logic [ID_W-1:0]      woken_id;
      logic                 last;
      logic                 status;
      logic [CNT_OUT_W-1:0] waiting_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INSERT,
      S_CHK_RD,
      S_CHK_CMP,
      S_REPLY
   } state_type;

endpackage

// ===== rtl/sorted_deadline_alarm_queue.sv =====
`timescale 1ns / 1ps
// sorted_deadline_alarm_queue: deadline-sorted alarm queue, top level.
// Depends on sdaq_pkg and sdaq_ram.

// Waiters are held in one RAM as a ring (head pointer plus count), each word
// {deadline, id}, kept in deadline order. A sleep item works out
// deadline = now + duration * ticks_per_unit (multiplied in S_MUL, then
// added in S_ADD), scans from the head for the first entry due strictly
// later, moves the tail up one slot at a time and writes the new entry;
// each compare or move is a read/compare or read/write pair around the
// RAM's registered read. A full queue answers at once with the full status.
// A check item reads the head, pops it if its signed distance to now is zero
// or less and repeats. Each result is held back one step so that the final
// one can carry last. Items are taken one at a time; req_stall is high until
// the final result has been loaded into the output register. The RAM needs
// no clearing after reset: only entries below the count are ever used.
module sorted_deadline_alarm_queue
   import sdaq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ENT_W = TIME_WIDTH + ID_W;

   // ---------------------------------------------------------------- csr
   logic [TPU_W-1:0] tpu_ff;
   logic             csr_wr;
   logic             csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == REG_TICKS_PER_UNIT);
   assign csr_wr  = psel && penable && pwrite && pready;
   assign prdata  = csr_hit ? CSR_DATA_W'(tpu_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff <= TPU_RESET;
      end else if (csr_wr && csr_hit) begin
         tpu_ff <= pwdata[TPU_W-1:0];
      end
   end

   // ---------------------------------------------------------------- state
   state_type            state_ff, state_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;      // scan index / move index
   logic [CNT_W-1:0]     pos_ff, pos_in;      // insert position
   logic                 have_pend_ff, have_pend_in;
   logic                 reply_status_ff, reply_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic                  op_ff, op_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [DUR_W-1:0]      dur_ff, dur_in;
   logic [TIME_WIDTH-1:0] now_ff, now_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [TIME_WIDTH-1:0] dl_ff, dl_in;
   logic [ID_W-1:0]       pend_id_ff, pend_id_in;
   logic [CNT_W-1:0]      pend_cnt_ff, pend_cnt_in;
   rsp_type               rsp_ff, rsp_in;

   // RAM
   logic                  ram_we;
   logic [PTR_W-1:0]      ram_waddr, ram_raddr;
   logic [ENT_W-1:0]      ram_wdata, ram_rdata;
   logic [TIME_WIDTH-1:0] rd_dl;
   logic [ID_W-1:0]       rd_id;

   logic out_free;
   logic head_due;

   assign rd_dl = ram_rdata[ENT_W-1:ID_W];
   assign rd_id = ram_rdata[ID_W-1:0];

   // ring slot of queue position ofs (ofs below depth)
   function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] hd,
                                             input logic [CNT_W-1:0] ofs);
      logic [PTR_W:0] sum;
      sum = {1'b0, hd} + (PTR_W+1)'(ofs);
      if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   // a later than b as a signed difference
   function automatic logic time_after(input logic [TIME_WIDTH-1:0] a,
                                       input logic [TIME_WIDTH-1:0] b);
      logic [TIME_WIDTH-1:0] d;
      d = a - b;
      return (d != '0) && !d[TIME_WIDTH-1];
   endfunction

   sdaq_ram #(
      .WIDTH(ENT_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign head_due  = !time_after(rd_dl, now_ff);

   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      pos_in          = pos_ff;
      have_pend_in    = have_pend_ff;
      reply_status_in = reply_status_ff;
      op_in           = op_ff;
      id_in           = id_ff;
      dur_in          = dur_ff;
      now_in          = now_ff;
      prod_in         = prod_ff;
      dl_in           = dl_ff;
      pend_id_in      = pend_id_ff;
      pend_cnt_in     = pend_cnt_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      ram_we          = 1'b0;
      ram_waddr       = slot(head_ff, idx_ff);
      ram_wdata       = ram_rdata;
      ram_raddr       = slot(head_ff, idx_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in           = req_data.operation;
               id_in           = req_data.waiter_id;
               dur_in          = req_data.duration;
               now_in          = TIME_WIDTH'(req_data.now);
               have_pend_in    = 1'b0;
               reply_status_in = STATUS_OK;
               idx_in          = '0;
               if (req_data.operation == OP_SLEEP) begin
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     reply_status_in = STATUS_FULL;
                     state_in        = S_REPLY;
                  end else begin
                     state_in = S_MUL;
                  end
               end else begin
                  state_in = S_CHK_RD;
               end
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(dur_ff) * PROD_W'(tpu_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            dl_in    = now_ff + TIME_WIDTH'(prod_ff);
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               pos_in   = count_ff;   // nothing later: goes at the tail
               idx_in   = count_ff;
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (time_after(rd_dl, dl_ff)) begin
               pos_in   = idx_ff;
               idx_in   = count_ff;
               state_in = S_SHIFT_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            // reads always sit below the last write, so no overlap
            ram_raddr = slot(head_ff, idx_ff - 1'b1);
            if (idx_ff == pos_ff) begin
               state_in = S_INSERT;
            end else begin
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            ram_we   = 1'b1;
            ram_wdata = ram_rdata;
            idx_in   = idx_ff - 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_INSERT: begin
            ram_we    = 1'b1;
            ram_waddr = slot(head_ff, pos_ff);
            ram_wdata = {dl_ff, id_ff};
            count_in  = count_ff + 1'b1;
            state_in  = S_REPLY;
         end
         S_CHK_RD: begin
            ram_raddr = head_ff;
            if (count_ff == '0) begin
               state_in = S_REPLY;
            end else begin
               state_in = S_CHK_CMP;
            end
         end
         S_CHK_CMP: begin
            ram_raddr = head_ff;   // keeps the head word steady while stalled
            if (!head_due) begin
               state_in = S_REPLY;
            end else if (!have_pend_ff || out_free) begin
               if (have_pend_ff) begin
                  rsp_in       = '{woke: 1'b1, woken_id: pend_id_ff, last: 1'b0,
                                   status: STATUS_OK,
                                   waiting_count: CNT_OUT_W'(pend_cnt_ff)};
                  rsp_valid_in = 1'b1;
               end
               have_pend_in = 1'b1;
               pend_id_in   = rd_id;
               pend_cnt_in  = count_ff - 1'b1;
               count_in     = count_ff - 1'b1;
               head_in      = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : head_ff + 1'b1;
               state_in     = S_CHK_RD;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               if (have_pend_ff) begin
                  rsp_in = '{woke: 1'b1, woken_id: pend_id_ff, last: 1'b1,
                             status: STATUS_OK,
                             waiting_count: CNT_OUT_W'(pend_cnt_ff)};
               end else begin
                  rsp_in = '{woke: 1'b0, woken_id: '0, last: 1'b1,
                             status: reply_status_ff,
                             waiting_count: CNT_OUT_W'(count_ff)};
               end
               rsp_valid_in = 1'b1;
               have_pend_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         head_ff         <= '0;
         count_ff        <= '0;
         idx_ff          <= '0;
         pos_ff          <= '0;
         have_pend_ff    <= 1'b0;
         reply_status_ff <= STATUS_OK;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         head_ff         <= head_in;
         count_ff        <= count_in;
         idx_ff          <= idx_in;
         pos_ff          <= pos_in;
         have_pend_ff    <= have_pend_in;
         reply_status_ff <= reply_status_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      dur_ff      <= dur_in;
      now_ff      <= now_in;
      prod_ff     <= prod_in;
      dl_ff       <= dl_in;
      pend_id_ff  <= pend_id_in;
      pend_cnt_ff <= pend_cnt_in;
      rsp_ff      <= rsp_in;
   end

   // ---------------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_full_reply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY && reply_status_ff == STATUS_FULL)
         |-> (count_ff == CNT_W'(QUEUE_DEPTH) && op_ff == OP_SLEEP))
      else $error("full status without a full queue");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (op_ff == OP_SLEEP && state_ff != S_IDLE))
      else $error("store written outside a sleep insert");

   a_woke_on_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && rsp_in.woke && !(rsp_valid_ff && rsp_stall))
         |-> op_ff == OP_CHECK)
      else $error("woken waiter reported for a sleep item");

endmodule

// ===== rtl/sdaq_ram.sv =====
`timescale 1ns / 1ps
// sdaq_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sdaq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== dv/sorted_deadline_alarm_queue_tb.sv =====
`timescale 1ns / 1ps
// sorted_deadline_alarm_queue_tb: self-checking bench for the deadline alarm queue.
// Depends on sdaq_pkg and sorted_deadline_alarm_queue; predicts every result in a
// small scoreboard class and checks it against what the block returns.
module sorted_deadline_alarm_queue_tb;
   import sdaq_pkg::*;

   // Gaps with nothing accepted on any port before the run is declared hung.
   // The slowest correct stretch is a long sender gap, a full-depth insert
   // and a long receiver stall, well under this.
   localparam int STUCK_LIMIT      = 2000;
   // Worst-case insert latency plus margin, waited out at the very end.
   localparam int DRAIN_CYCLES     = 80;
   localparam int PHASES           = 8;
   localparam int ITEMS_PER_PHASE  = 50;
   // Byte address of ticks_per_unit: register index times four.
   localparam logic [CSR_ADDR_W-1:0] TPU_ADDR = {REG_TICKS_PER_UNIT, 2'b00};

   // Shadow of the queue: same ordering rules as the block, kept in plain arrays.
   // accept_item() works out every result an accepted item must produce and
   // queues them; match_result() takes the oldest and compares field by field.
   class wake_schedule;
      logic [NOW_W-1:0] deadline [QUEUE_DEPTH_DEF];
      logic [ID_W-1:0]  waiter [QUEUE_DEPTH_DEF];
      int               occupancy;
      logic [TPU_W-1:0] rate;
      rsp_type          awaited[$];
      int               errors, sleeps, checks, wakes, drops, results;

      function new();
         occupancy = 0;
         rate      = TPU_RESET;
         errors    = 0;
         sleeps    = 0;
         checks    = 0;
         wakes     = 0;
         drops     = 0;
         results   = 0;
      endfunction

      // a strictly later than b, as a signed difference on the time ring
      function bit later(logic [NOW_W-1:0] a, logic [NOW_W-1:0] b);
         logic [NOW_W-1:0] d;
         d = a - b;
         return d != '0 && !d[NOW_W-1];
      endfunction

      function rsp_type outcome(logic woke, logic [ID_W-1:0] id, logic last, logic status);
         rsp_type r;
         r.woke          = woke;
         r.woken_id      = id;
         r.last          = last;
         r.status        = status;
         r.waiting_count = CNT_OUT_W'(occupancy);
         return r;
      endfunction

      function void accept_item(req_type it);
         logic [NOW_W-1:0] dl;
         logic [ID_W-1:0]  id;
         rsp_type          held;
         bit               have;
         int               pos;
         if (it.operation == OP_SLEEP) begin
            sleeps++;
            if (occupancy >= QUEUE_DEPTH_DEF) begin
               drops++;
               awaited.push_back(outcome(1'b0, '0, 1'b1, STATUS_FULL));
               return;
            end
            dl  = it.now + it.duration * rate;
            pos = occupancy;
            // backwards scan leaves pos on the first entry due later than dl
            for (int i = occupancy - 1; i >= 0; i--)
               if (later(deadline[i], dl)) pos = i;
            for (int i = occupancy; i > pos; i--) begin
               deadline[i] = deadline[i-1];
               waiter[i]   = waiter[i-1];
            end
            deadline[pos] = dl;
            waiter[pos]   = it.waiter_id;
            occupancy++;
            awaited.push_back(outcome(1'b0, '0, 1'b1, STATUS_OK));
         end else begin
            checks++;
            have = 1'b0;
            // each wake is held back one step so the final one can carry last
            while (occupancy > 0 && !later(deadline[0], it.now)) begin
               if (have) awaited.push_back(held);
               id = waiter[0];
               for (int i = 1; i < occupancy; i++) begin
                  deadline[i-1] = deadline[i];
                  waiter[i-1]   = waiter[i];
               end
               occupancy--;
               held = outcome(1'b1, id, 1'b0, STATUS_OK);
               have = 1'b1;
               wakes++;
            end
            if (have) begin
               held.last = 1'b1;
               awaited.push_back(held);
            end else begin
               awaited.push_back(outcome(1'b0, '0, 1'b1, STATUS_OK));
            end
         end
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         string   bad;
         results++;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected result woke=%0d id=%0d last=%0d status=%0d count=%0d",
                     $time, got.woke, got.woken_id, got.last, got.status, got.waiting_count);
            return;
         end
         want = awaited.pop_front();
         bad  = "";
         if (got.woke !== want.woke)                   bad = {bad, " woke"};
         if (got.woken_id !== want.woken_id)           bad = {bad, " woken_id"};
         if (got.last !== want.last)                   bad = {bad, " last"};
         if (got.status !== want.status)               bad = {bad, " status"};
         if (got.waiting_count !== want.waiting_count) bad = {bad, " waiting_count"};
         if (bad != "") begin
            errors++;
            $display("%0t: mismatch in%s: expected woke=%0d id=%0d last=%0d status=%0d count=%0d",
                     $time, bad, want.woke, want.woken_id, want.last, want.status,
                     want.waiting_count);
            $display("%0t:   actual woke=%0d id=%0d last=%0d status=%0d count=%0d",
                     $time, got.woke, got.woken_id, got.last, got.status, got.waiting_count);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   wake_schedule     sb;
   int               gap_pct = 0;      // chance per cycle that the sender holds off
   int               stall_pct = 0;    // chance per cycle that the receiver stalls
   int               csr_errors = 0;
   int               rate_settings = 0;
   logic [NOW_W-1:0] clk_now = '0;     // running system time for the random part

   sorted_deadline_alarm_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Result side: everything is read at the edge, before the registers update,
   // so the values seen are those the edge samples. Stall is redrawn every cycle.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.match_result(rsp_data);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Hang detector: counts cycles in which no port moves anything.
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (psel && penable && pready))
            stuck = 0;
         else
            stuck++;
      end
      $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // Offer one item, with random hold-off first; valid is raised only once the
   // gap is over, and stays up with the same payload until accepted.
   task automatic send(input req_type it);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.accept_item(it);
   endtask

   task automatic sleep_item(input logic [ID_W-1:0] id, input logic [DUR_W-1:0] dur,
                             input logic [NOW_W-1:0] now);
      req_type it;
      it.operation = OP_SLEEP;
      it.waiter_id = id;
      it.duration  = dur;
      it.now       = now;
      send(it);
   endtask

   task automatic check_item(input logic [NOW_W-1:0] now);
      req_type it;
      it.operation = OP_CHECK;
      it.waiter_id = ID_W'($urandom_range(255));
      it.duration  = DUR_W'($urandom());
      it.now       = now;
      send(it);
   endtask

   // Drop valid and let every awaited result come home before touching registers.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Read ticks_per_unit back and compare it with what was last written.
   task automatic check_rate(input logic [TPU_W-1:0] want);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= TPU_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(want)) begin
         csr_errors++;
         $display("%0t: ticks_per_unit read back: expected %0d, got %0d", $time, want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Setup then access; the register takes the value at the access edge.
   task automatic program_rate(input logic [TPU_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= TPU_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.rate = value;
      rate_settings++;
      check_rate(value);
   endtask

   // Mostly well-formed traffic: sleeps at the running time with short
   // durations, checks that move time forward by a few units so waiters fall
   // due. A small share is noise with an arbitrary time and any operation.
   function automatic req_type random_item(int sleep_pct, int rate);
      req_type it;
      int      roll;
      int      pick;
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      it.waiter_id = ID_W'($urandom_range(255));
      if (roll < 8) begin
         it.operation = 1'($urandom_range(1));
         it.duration  = DUR_W'($urandom());
         it.now       = NOW_W'($urandom());
      end else if (roll < 8 + sleep_pct * 92 / 100) begin
         it.operation = OP_SLEEP;
         if (pick < 80)      it.duration = DUR_W'($urandom_range(20));
         else if (pick < 90) it.duration = DUR_W'($urandom());
         else if (pick < 95) it.duration = '1;
         else                it.duration = '0;
         it.now = clk_now;
      end else begin
         it.operation = OP_CHECK;
         it.duration  = DUR_W'($urandom());
         clk_now      = clk_now + NOW_W'($urandom_range((rate + 1) * 12));
         it.now       = clk_now;
      end
      return it;
   endfunction

   initial begin : stimulus
      logic [TPU_W-1:0] rate_plan [PHASES];
      logic [TPU_W-1:0] rate;
      rate_plan = '{10'd1, 10'd1000, 10'd100, 10'd0, 10'd7, 10'd1000, 10'd1, 10'd100};
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_rate(TPU_RESET);

      // Directed part. With a zero rate the deadline is just the given time,
      // which makes the corner cases easy to place.
      program_rate('0);
      sleep_item(8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
      check_item(32'hFFFF_FFFE);                 // one tick early: nothing due
      check_item(32'hFFFF_FFFF);                 // exactly on time
      sleep_item(8'h00, 16'h0000, 32'h0000_0000);
      sleep_item(8'h01, 16'h1234, 32'h8000_0000); // half a ring away, goes at the tail
      check_item(32'hC000_0000);                 // head not due, entry behind it is: stop
      sleep_item(8'h02, 16'h0000, 32'h0000_0000); // tie with the head, must follow it
      check_item(32'h0000_0000);                 // wakes all three in order

      // Largest rate: fill the queue across the time wrap, overflow it by
      // one, then wake all sixteen with a single check.
      wait_idle();
      program_rate(10'd1000);
      for (int k = 0; k < QUEUE_DEPTH_DEF + 1; k++)
         sleep_item(ID_W'(k * 15), (k == 15) ? '1 : (k == 3) ? '0 : DUR_W'($urandom_range(40)),
                    32'hFFFF_0000 + NOW_W'(k));
      check_item(32'h0400_0000);

      // Random part: each phase picks a rate and one of four idle mixes
      // (none, sender idle, receiver stalling, both lightly).
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         rate = (ph == PHASES - 1) ? TPU_W'($urandom_range(1000, 1)) : rate_plan[ph];
         program_rate(rate);
         case (ph % 4)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 69;
               stall_pct = 0;
            end
            2: begin
               gap_pct   = 0;
               stall_pct = 69;
            end
            default: begin
               gap_pct   = 14;
               stall_pct = 14;
            end
         endcase
         // start some phases just short of the wrap so it gets crossed
         clk_now = (ph % 3 == 0) ? 32'hFFFF_FFFF - NOW_W'($urandom_range(50000))
                                 : NOW_W'($urandom());
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send(random_item((ph % 2 == 1) ? 70 : 50, rate));
      end

      gap_pct   = 0;
      stall_pct = 0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d items: %0d sleeps (%0d refused on a full queue), %0d checks,",
               sb.sleeps + sb.checks, sb.sleeps, sb.drops, sb.checks);
      $display("%0d results with %0d waiters woken, over %0d rate settings and four idle mixes.",
               sb.results, sb.wakes, rate_settings);
      if (sb.errors == 0 && csr_errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
